// ===== src/fpc_pkg.sv =====
package fpc_pkg;

    // Item kinds
    localparam logic [3:0] KIND_TICK       = 4'd0;
    localparam logic [3:0] KIND_ABS_MOVE   = 4'd1;
    localparam logic [3:0] KIND_REL_MOVE   = 4'd2;
    localparam logic [3:0] KIND_HALT       = 4'd3;
    localparam logic [3:0] KIND_SYNC       = 4'd4;
    localparam logic [3:0] KIND_RD_POS     = 4'd5;
    localparam logic [3:0] KIND_RD_MOVING  = 4'd6;
    localparam logic [3:0] KIND_RD_LIMIT   = 4'd7;
    localparam logic [3:0] KIND_SET_LIMIT  = 4'd8;
    localparam logic [3:0] KIND_RD_BKL     = 4'd9;
    localparam logic [3:0] KIND_SET_BKL    = 4'd10;
    localparam logic [3:0] KIND_RD_REV     = 4'd11;
    localparam logic [3:0] KIND_SET_REV    = 4'd12;

    // Reply status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Field and state widths
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 20;
    localparam int BKL_W   = 14;
    localparam int STEP_W  = 16;

    // Register map (word index)
    localparam logic REG_STEP_PER_TICK = 1'b0;

    // Limits and reset values
    localparam int LIMIT_MIN     = 100;
    localparam int LIMIT_MAX     = 1000000;
    localparam int BACKLASH_MAX  = 10000;
    localparam logic [STEP_W-1:0] STEP_RESET     = 16'd200;
    localparam logic [POS_W-1:0]  POSITION_RESET = 20'd50000;
    localparam logic [POS_W-1:0]  LIMIT_RESET    = 20'd100000;

    typedef struct packed {
        logic                      status;
        logic signed [VALUE_W-1:0] reply_value;
    } fpc_result_t;

endpackage

// ===== src/fpc_if.sv =====
interface fpc_cmd_if;
    import fpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface fpc_rsp_if;
    import fpc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      status;
    logic signed [VALUE_W-1:0] reply_value;

    modport source (output valid, output status, output reply_value, input ready);
    modport sink   (input valid, input status, input reply_value, output ready);
endinterface

// ===== src/fpc_cfg_regs.sv =====
module fpc_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [fpc_pkg::STEP_W-1:0] step_per_tick
);
    import fpc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_STEP_PER_TICK);

    // Take the low half-word on a completed write
    always_comb
    begin
        step_next = step_reg;
        if (wr_en)
        begin
            step_next = pwdata[STEP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // Read back; unmapped words read as zero
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_STEP_PER_TICK)
        begin
            prdata = {{(32-STEP_W){1'b0}}, step_reg};
        end
    end

    assign step_per_tick = step_reg;

endmodule

// ===== src/fpc_core.sv =====
module fpc_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             fire,
    input  logic [fpc_pkg::KIND_W-1:0]       kind,
    input  logic signed [fpc_pkg::VALUE_W-1:0] value,
    input  logic [fpc_pkg::STEP_W-1:0]       step_per_tick,
    output fpc_pkg::fpc_result_t             result
);
    import fpc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] tgt_reg, tgt_next;
    logic [POS_W-1:0] limit_reg, limit_next;
    logic [BKL_W-1:0] bkl_reg, bkl_next;
    logic             rev_reg, rev_next;

    logic signed [33:0]  value_wide;
    logic signed [33:0]  rel_sum;
    logic [POS_W-1:0]    abs_clamped;
    logic [POS_W-1:0]    rel_clamped;
    logic signed [POS_W:0] delta;
    logic [POS_W-1:0]    delta_mag;
    logic [POS_W-1:0]    step_wide;
    logic [POS_W-1:0]    move_amt;
    logic                limit_bad;
    logic                rev_ok;
    logic [BKL_W-1:0]    bkl_clamped;

    // Clamp a wide signed value to 0..lim
    function automatic logic [POS_W-1:0] clamp_pos(
        input logic signed [33:0] x,
        input logic [POS_W-1:0]   lim
    );
        logic [POS_W-1:0] r;
        if (x < 34'sd0)
        begin
            r = '0;
        end
        else if (x > $signed({{(34-POS_W){1'b0}}, lim}))
        begin
            r = lim;
        end
        else
        begin
            r = x[POS_W-1:0];
        end
        return r;
    endfunction

    assign value_wide  = {{2{value[VALUE_W-1]}}, value};
    assign rel_sum     = $signed({{(34-POS_W){1'b0}}, pos_reg}) + value_wide;
    assign abs_clamped = clamp_pos(value_wide, limit_reg);
    assign rel_clamped = clamp_pos(rel_sum, limit_reg);

    // Tick step: distance to target, limited by step size
    assign delta     = $signed({1'b0, tgt_reg}) - $signed({1'b0, pos_reg});
    assign delta_mag = (delta < 0) ? POS_W'(-delta) : POS_W'(delta);
    assign step_wide = {{(POS_W-STEP_W){1'b0}}, step_per_tick};
    assign move_amt  = (delta_mag < step_wide) ? delta_mag : step_wide;

    // Argument checks
    assign limit_bad = (value < 32'(LIMIT_MIN)) || (value > 32'(LIMIT_MAX))
                       || ($signed({{(VALUE_W-POS_W){1'b0}}, pos_reg}) > value);
    assign rev_ok    = (value == 32'sd0) || (value == 32'sd1);

    always_comb
    begin
        if (value < 32'sd0)
        begin
            bkl_clamped = '0;
        end
        else if (value > 32'(BACKLASH_MAX))
        begin
            bkl_clamped = BKL_W'(BACKLASH_MAX);
        end
        else
        begin
            bkl_clamped = value[BKL_W-1:0];
        end
    end

    // Next state and reply
    always_comb
    begin
        pos_next   = pos_reg;
        tgt_next   = tgt_reg;
        limit_next = limit_reg;
        bkl_next   = bkl_reg;
        rev_next   = rev_reg;
        result.status      = STATUS_OK;
        result.reply_value = '0;
        case (kind)
            KIND_TICK:
            begin
                if (delta > 0)
                begin
                    pos_next = pos_reg + move_amt;
                end
                else if (delta < 0)
                begin
                    pos_next = pos_reg - move_amt;
                end
            end
            KIND_ABS_MOVE:
            begin
                tgt_next = abs_clamped;
                result.reply_value = value;
            end
            KIND_REL_MOVE:
            begin
                tgt_next = rel_clamped;
                result.reply_value = value;
            end
            KIND_HALT:
            begin
                tgt_next = pos_reg;
            end
            KIND_SYNC:
            begin
                pos_next = abs_clamped;
                tgt_next = abs_clamped;
                result.reply_value = {{(VALUE_W-POS_W){1'b0}}, abs_clamped};
            end
            KIND_RD_POS:
            begin
                result.reply_value = {{(VALUE_W-POS_W){1'b0}}, pos_reg};
            end
            KIND_RD_MOVING:
            begin
                result.reply_value = {{(VALUE_W-1){1'b0}}, (pos_reg != tgt_reg)};
            end
            KIND_RD_LIMIT:
            begin
                result.reply_value = {{(VALUE_W-POS_W){1'b0}}, limit_reg};
            end
            KIND_SET_LIMIT:
            begin
                if (limit_bad)
                begin
                    result.status = STATUS_ERR;
                end
                else
                begin
                    limit_next = value[POS_W-1:0];
                    tgt_next   = pos_reg;
                    result.reply_value = value;
                end
            end
            KIND_RD_BKL:
            begin
                result.reply_value = {{(VALUE_W-BKL_W){1'b0}}, bkl_reg};
            end
            KIND_SET_BKL:
            begin
                bkl_next = bkl_clamped;
                result.reply_value = {{(VALUE_W-BKL_W){1'b0}}, bkl_clamped};
            end
            KIND_RD_REV:
            begin
                result.reply_value = {{(VALUE_W-1){1'b0}}, rev_reg};
            end
            KIND_SET_REV:
            begin
                if (rev_ok)
                begin
                    rev_next = value[0];
                    tgt_next = pos_reg;
                    result.reply_value = value;
                end
                else
                begin
                    result.status = STATUS_ERR;
                end
            end
            default:
            begin
                result.status = STATUS_ERR;
            end
        endcase
    end

    // Commit state when the item leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POSITION_RESET;
            tgt_reg   <= POSITION_RESET;
            limit_reg <= LIMIT_RESET;
            bkl_reg   <= '0;
            rev_reg   <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            tgt_reg   <= tgt_next;
            limit_reg <= limit_next;
            bkl_reg   <= bkl_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

// ===== src/focuser_position_controller.sv =====
// Focuser position controller. Each transfer on cmd carries one decoded command
// or one time tick; every command yields exactly one transfer on rsp (status 0
// with a value, or status 1 with zero), a tick yields none and moves the position
// toward the target by at most step_per_tick steps (APB register 0, reset 200).
// An item is held in an input register until it can advance (a command needs
// a free output register, a tick does not), is evaluated and committed to the
// state as it leaves, and a command's reply lands in the output register, which
// drives rsp.valid. The block sustains one item per cycle; throughput drops
// only while rsp.ready is low and the output register is full. step_per_tick
// may be written only while no item is in flight.
module focuser_position_controller (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    fpc_cmd_if.sink      cmd,
    fpc_rsp_if.source    rsp
);
    import fpc_pkg::*;

    logic [STEP_W-1:0]         step_per_tick;
    logic                      in_valid_reg, in_valid_next;
    logic [KIND_W-1:0]         in_kind_reg;
    logic signed [VALUE_W-1:0] in_value_reg;
    logic                      out_valid_reg, out_valid_next;
    fpc_result_t               out_reg;
    fpc_result_t               core_result;
    logic                      is_tick;
    logic                      out_free;
    logic                      advance;
    logic                      cmd_xfer;

    fpc_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .step_per_tick (step_per_tick)
    );

    fpc_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .kind          (in_kind_reg),
        .value         (in_value_reg),
        .step_per_tick (step_per_tick),
        .result        (core_result)
    );

    // Advance when the held item has somewhere to go
    assign is_tick   = (in_kind_reg == KIND_TICK);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && (is_tick || out_free);
    assign cmd.ready = !in_valid_reg || advance;
    assign cmd_xfer  = cmd.valid && cmd.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && !is_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the payload on a cmd transfer
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            in_kind_reg  <= cmd.kind;
            in_value_reg <= cmd.value;
        end
    end

    // Load the reply register
    always_ff @(posedge clk)
    begin
        if (advance && !is_tick)
        begin
            out_reg <= core_result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.reply_value = out_reg.reply_value;

endmodule

// ===== verif/focuser_position_controller_test.sv =====
module focuser_position_controller_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int GAP_MAX      = 19;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 300;
    localparam int DELTA_SPAN   = 20000;
    localparam int MAX_REPORTS  = 100;
    localparam int RUN_LIMIT_NS = 5_000_000;

    // Command codes the package leaves unnamed
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 4'd13;
    localparam logic [KIND_W-1:0] KIND_RSVD_A    = 4'd14;
    localparam logic [KIND_W-1:0] KIND_RSVD_B    = 4'd15;

    // Register byte addresses; the upper word is unmapped
    localparam logic [2:0] ADDR_STEP  = {REG_STEP_PER_TICK, 2'b00};
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    typedef struct {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        bit                        known;
        logic                      status;
        logic signed [VALUE_W-1:0] reply;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fpc_cmd_if cmd ();
    fpc_rsp_if rsp ();

    // Predicted controller state
    logic [POS_W-1:0]  pred_position;
    logic [POS_W-1:0]  pred_target;
    logic [POS_W-1:0]  pred_limit;
    logic [BKL_W-1:0]  pred_backlash;
    logic              pred_reverse;
    logic [STEP_W-1:0] pred_step;

    fpc_result_t expected_replies [$];
    int          mismatches;
    int          cmd_gap_max;
    int          rsp_gap_max;
    bit          hold_rsp;

    // Known replies are typed in; the rest come from the predictor
    directed_row_t directed_rows [27] = '{
        '{KIND_RD_POS,    32'sd0,           1'b1, STATUS_OK,  32'sd50000},
        '{KIND_RD_LIMIT,  32'sd0,           1'b1, STATUS_OK,  32'sd100000},
        '{KIND_RD_BKL,    32'sd0,           1'b1, STATUS_OK,  32'sd0},
        '{KIND_RD_REV,    32'sd0,           1'b1, STATUS_OK,  32'sd0},
        '{KIND_RD_MOVING, 32'sd0,           1'b1, STATUS_OK,  32'sd0},
        '{KIND_MALFORMED, 32'sh7FFF_FFFF,   1'b1, STATUS_ERR, 32'sd0},
        '{KIND_RSVD_A,    32'sd1,           1'b1, STATUS_ERR, 32'sd0},
        '{KIND_RSVD_B,    -32'sd1,          1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_LIMIT, 32'sd99,          1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_LIMIT, 32'sd1000001,     1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_LIMIT, 32'sd100,         1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_LIMIT, 32'sd1000000,     1'b1, STATUS_OK,  32'sd1000000},
        '{KIND_ABS_MOVE,  32'sh7FFF_FFFF,   1'b1, STATUS_OK,  32'sh7FFF_FFFF},
        '{KIND_TICK,      32'sd0,           1'b0, STATUS_OK,  32'sd0},
        '{KIND_RD_MOVING, 32'sd0,           1'b1, STATUS_OK,  32'sd1},
        '{KIND_REL_MOVE,  32'sh8000_0000,   1'b1, STATUS_OK,  32'sh8000_0000},
        '{KIND_TICK,      32'sd0,           1'b0, STATUS_OK,  32'sd0},
        '{KIND_RD_POS,    32'sd0,           1'b0, STATUS_OK,  32'sd0},
        '{KIND_SET_BKL,   -32'sd5,          1'b1, STATUS_OK,  32'sd0},
        '{KIND_SET_BKL,   32'sd20000,       1'b1, STATUS_OK,  32'sd10000},
        '{KIND_SET_REV,   32'sd2,           1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_REV,   -32'sd1,          1'b1, STATUS_ERR, 32'sd0},
        '{KIND_SET_REV,   32'sd1,           1'b1, STATUS_OK,  32'sd1},
        '{KIND_HALT,      32'sh5A5A_A5A5,   1'b1, STATUS_OK,  32'sd0},
        '{KIND_SYNC,      -32'sd1,          1'b1, STATUS_OK,  32'sd0},
        '{KIND_SYNC,      32'sh7FFF_FFFF,   1'b1, STATUS_OK,  32'sd1000000},
        '{KIND_REL_MOVE,  32'sh7FFF_FFFF,   1'b1, STATUS_OK,  32'sh7FFF_FFFF}
    };

    focuser_position_controller dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .rsp     (rsp)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // Print one line per mismatch, capped, and count every one
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("mismatch %s: got %0d (0x%08h), expected %0d (0x%08h)",
                     what, $signed(got), got, $signed(want), want);
        end
    endtask

    function automatic longint clamp_span(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predicted state by one item; return 1 when a reply is due
    function automatic bit predict_reply(input logic [KIND_W-1:0] kind,
                                         input logic signed [VALUE_W-1:0] value,
                                         output fpc_result_t res);
        longint arg;
        longint pos;
        longint tgt;
        longint lim;
        longint remaining;
        longint stride;
        longint bkl;
        bit     err;

        arg    = longint'(value);
        pos    = longint'(pred_position);
        tgt    = longint'(pred_target);
        lim    = longint'(pred_limit);
        stride = longint'(pred_step);
        err    = 1'b0;
        res.status      = STATUS_OK;
        res.reply_value = '0;

        case (kind)
            KIND_TICK:
            begin
                // Step toward target, never past it
                remaining = tgt - pos;
                if (remaining > 0)
                    pos = pos + ((remaining < stride) ? remaining : stride);
                else if (remaining < 0)
                    pos = pos - ((-remaining < stride) ? -remaining : stride);
                pred_position = POS_W'(pos);
                return 1'b0;
            end
            KIND_ABS_MOVE:
            begin
                tgt = clamp_span(arg, 0, lim);
                res.reply_value = value;
            end
            KIND_REL_MOVE:
            begin
                tgt = clamp_span(pos + arg, 0, lim);
                res.reply_value = value;
            end
            KIND_HALT:
            begin
                tgt = pos;
            end
            KIND_SYNC:
            begin
                pos = clamp_span(arg, 0, lim);
                tgt = pos;
                res.reply_value = VALUE_W'(pos);
            end
            KIND_RD_POS:
            begin
                res.reply_value = VALUE_W'(pos);
            end
            KIND_RD_MOVING:
            begin
                res.reply_value = (pos != tgt) ? 32'sd1 : 32'sd0;
            end
            KIND_RD_LIMIT:
            begin
                res.reply_value = VALUE_W'(lim);
            end
            KIND_SET_LIMIT:
            begin
                if (arg < longint'(LIMIT_MIN) || arg > longint'(LIMIT_MAX) || pos > arg)
                begin
                    err = 1'b1;
                end
                else
                begin
                    lim = arg;
                    tgt = pos;
                    res.reply_value = value;
                end
            end
            KIND_RD_BKL:
            begin
                res.reply_value = VALUE_W'(pred_backlash);
            end
            KIND_SET_BKL:
            begin
                bkl = clamp_span(arg, 0, longint'(BACKLASH_MAX));
                pred_backlash = BKL_W'(bkl);
                res.reply_value = VALUE_W'(bkl);
            end
            KIND_RD_REV:
            begin
                res.reply_value = VALUE_W'(pred_reverse);
            end
            KIND_SET_REV:
            begin
                if (arg != 0 && arg != 1)
                begin
                    err = 1'b1;
                end
                else
                begin
                    pred_reverse = value[0];
                    tgt = pos;
                    res.reply_value = value;
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase

        if (err)
        begin
            res.status      = STATUS_ERR;
            res.reply_value = '0;
        end
        pred_position = POS_W'(pos);
        pred_target   = POS_W'(tgt);
        pred_limit    = POS_W'(lim);
        return 1'b1;
    endfunction

    // Offer one command after a random gap; predict it once the transfer happens
    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic signed [VALUE_W-1:0] value,
                             input bit known, input fpc_result_t known_reply);
        int          gap;
        fpc_result_t res;

        gap = $urandom_range(0, cmd_gap_max);
        if (gap != 0)
        begin
            cmd.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd.kind  = kind;
        cmd.value = value;
        cmd.valid = 1'b1;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (predict_reply(kind, value, res))
            expected_replies.push_back(known ? known_reply : res);
        @(negedge clk);
    endtask

    // Write a register, then read the step register back
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        logic [31:0] readback;

        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_STEP)
            pred_step = data[STEP_W-1:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_STEP;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback[STEP_W-1:0] !== pred_step)
            report_mismatch("step readback", 32'(readback[STEP_W-1:0]), 32'(pred_step));
    endtask

    // Drop valid, drain every pending reply, then let trailing ticks settle
    task automatic wait_idle();
        cmd.valid = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Reply sink: random stalls, one long hold-off when asked
    initial
    begin
        int gap;

        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
            end
            gap = $urandom_range(0, rsp_gap_max);
            if (gap != 0)
            begin
                rsp.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            @(negedge clk);
        end
    end

    // Check each reply transfer against the oldest expectation
    always @(posedge clk)
    begin
        fpc_result_t want;

        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                report_mismatch("unexpected reply", rsp.reply_value, 32'd0);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.reply_value !== want.reply_value)
                    report_mismatch("reply_value", rsp.reply_value, want.reply_value);
            end
        end
    end

    // Main sequence
    initial
    begin
        int                        r;
        int                        lim;
        int                        pos_lo;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [2:0]                addr;
        logic [31:0]               data;
        fpc_result_t               known_reply;

        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = ADDR_STEP;
        pwdata    = '0;
        cmd.valid = 1'b0;
        cmd.kind  = KIND_TICK;
        cmd.value = '0;

        pred_position = POSITION_RESET;
        pred_target   = POSITION_RESET;
        pred_limit    = LIMIT_RESET;
        pred_backlash = '0;
        pred_reverse  = 1'b0;
        pred_step     = STEP_RESET;
        mismatches    = 0;
        cmd_gap_max   = GAP_MAX;
        rsp_gap_max   = GAP_MAX;
        hold_rsp      = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table at the reset step size
        foreach (directed_rows[i])
        begin
            known_reply.status      = directed_rows[i].status;
            known_reply.reply_value = directed_rows[i].reply;
            send_item(directed_rows[i].kind, directed_rows[i].value,
                      directed_rows[i].known, known_reply);
        end
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            // Pick the step setting and the idling pattern for this phase
            addr = ADDR_STEP;
            cmd_gap_max = GAP_MAX;
            rsp_gap_max = GAP_MAX;
            case (p)
                0: data = 32'h0000_FFFF;
                1:
                begin
                    addr = ADDR_SPARE;
                    data = 32'hDEAD_0001;
                    cmd_gap_max = 0;
                    hold_rsp = 1'b1;
                end
                2:
                begin
                    data = 32'h0000_0000;
                    cmd_gap_max = 0;
                    rsp_gap_max = 0;
                end
                3: data = 32'h0000_0001;
                4: data = $urandom;
                default:
                begin
                    data = {16'hFFFF, STEP_RESET};
                    rsp_gap_max = 0;
                end
            endcase
            write_register(addr, data);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r      = $urandom_range(0, 99);
                lim    = int'(pred_limit);
                pos_lo = (int'(pred_position) > LIMIT_MIN) ? int'(pred_position) : LIMIT_MIN;
                value  = $urandom;
                if (r < 30)
                begin
                    kind = KIND_TICK;
                end
                else if (r < 40)
                begin
                    kind = KIND_ABS_MOVE;
                    if ($urandom_range(0, 3) != 0)
                        value = $urandom_range(0, lim);
                end
                else if (r < 48)
                begin
                    kind = KIND_REL_MOVE;
                    if ($urandom_range(0, 3) != 0)
                        value = int'($urandom_range(0, 2 * DELTA_SPAN)) - DELTA_SPAN;
                end
                else if (r < 51)
                begin
                    kind = KIND_HALT;
                end
                else if (r < 55)
                begin
                    kind = KIND_SYNC;
                    if ($urandom_range(0, 3) != 0)
                        value = $urandom_range(0, lim);
                end
                else if (r < 70)
                begin
                    case ($urandom_range(0, 4))
                        0: kind = KIND_RD_POS;
                        1: kind = KIND_RD_MOVING;
                        2: kind = KIND_RD_LIMIT;
                        3: kind = KIND_RD_BKL;
                        default: kind = KIND_RD_REV;
                    endcase
                end
                else if (r < 78)
                begin
                    // Mostly legal limits, some just above position, some anywhere
                    kind = KIND_SET_LIMIT;
                    case ($urandom_range(0, 3))
                        0: value = $urandom_range(pos_lo, LIMIT_MAX);
                        1: value = $urandom_range(pos_lo,
                                   (pos_lo + 2000 < LIMIT_MAX) ? pos_lo + 2000 : LIMIT_MAX);
                        2: value = $urandom_range(0, LIMIT_MAX + LIMIT_MIN);
                        default: ;
                    endcase
                end
                else if (r < 84)
                begin
                    kind = KIND_SET_BKL;
                    if ($urandom_range(0, 3) != 0)
                        value = int'($urandom_range(0, BACKLASH_MAX + 2000)) - 1000;
                end
                else if (r < 90)
                begin
                    kind = KIND_SET_REV;
                    if ($urandom_range(0, 3) != 0)
                        value = int'($urandom_range(0, 3)) - 1;
                end
                else if (r < 96)
                begin
                    kind = KIND_W'(int'(KIND_MALFORMED) + int'($urandom_range(0, 2)));
                end
                else
                begin
                    kind = KIND_W'($urandom_range(0, 15));
                end
                send_item(kind, value, 1'b0, '0);
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
